// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define CHK_IMPLY(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is low.
`define CHK_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ===== hw/rtl/gbf_pkg.sv =====
// Package for the Gaussian bump field evaluator: widths, register codes,
// and the exp(-r2) lookup table built at elaboration. No dependencies.
package gbf_pkg;

  localparam int EXP_TABLE_ENTRIES = 256;
  localparam int EXP_K_W   = $clog2(EXP_TABLE_ENTRIES);
  localparam int EXP_IDX_W = $clog2(EXP_TABLE_ENTRIES + 1);
  localparam int EXP_P_W   = 32 + EXP_K_W;

  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BASE_COEF  = 4'd0,
    REG_BUMP_DEPTH = 4'd1,
    REG_CENTER_X   = 4'd2,
    REG_CENTER_Y   = 4'd3,
    REG_INV_W_X    = 4'd4,
    REG_INV_W_Y    = 4'd5,
    REG_CELL_X     = 4'd6,
    REG_CELL_Y     = 4'd7
  } cfg_reg_e;

  typedef logic [16:0] exp_tab_t [EXP_TABLE_ENTRIES+1];

  // Integer quotient by restoring shift and subtract, evaluated at elaboration
  function automatic logic [63:0] div_u64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] q;
    logic [64:0] rem;
    q   = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem  = rem - {1'b0, den};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // Build exp(-64 n / N) in Q.16: Taylor series for exp(-1/N), six squarings,
  // then repeated multiplication, all in Q.62 with floor products.
  function automatic exp_tab_t build_exp_tab();
    logic [63:0]  t;
    logic [63:0]  sum;
    logic [63:0]  s;
    logic [63:0]  e;
    logic [127:0] pr;
    exp_tab_t     tab;
    t   = 64'h4000_0000_0000_0000;
    sum = t;
    for (int k = 1; k < 64; k++) begin
      if (t != 64'd0) begin
        t = div_u64(t, 64'(k) * 64'(EXP_TABLE_ENTRIES));
        if (k[0]) sum = sum - t;
        else      sum = sum + t;
      end
    end
    s = sum;
    for (int n = 0; n < 6; n++) begin
      pr = {64'd0, s} * {64'd0, s};
      s  = pr[125:62];
    end
    e = 64'h4000_0000_0000_0000;
    for (int n = 0; n <= EXP_TABLE_ENTRIES; n++) begin
      tab[n] = 17'((e + 64'h0000_2000_0000_0000) >> 46);
      pr     = {64'd0, e} * {64'd0, s};
      e      = pr[125:62];
    end
    return tab;
  endfunction

  localparam exp_tab_t EXP_TAB = build_exp_tab();

endpackage

// ===== hw/rtl/gbf_in_if.sv =====
// Request channel carrying one grid cell index pair.
// Depends on nothing.
interface gbf_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] cell_i;
  logic signed [15:0] cell_j;

  modport source (output valid, output cell_i, output cell_j, input ready);
  modport sink   (input valid, input cell_i, input cell_j, output ready);
endinterface

// ===== hw/rtl/gbf_out_if.sv =====
// Result channel carrying one friction coefficient.
// Depends on nothing.
interface gbf_out_if;
  logic               valid;
  logic               ready;
  logic signed [35:0] coefficient;

  modport source (output valid, output coefficient, input ready);
  modport sink   (input valid, input coefficient, output ready);
endinterface

// ===== hw/rtl/gbf_axis.sv =====
// One axis: cell centre offset, inverse width scaling, rounding and square.
// Five register stages; depends on gbf_pkg.
module gbf_axis
  import gbf_pkg::*;
(
  input  logic               clk_i,
  input  logic               en_i,
  input  logic signed [15:0] cell_i,
  input  logic        [30:0] cell_size_i,
  input  logic signed [31:0] center_i,
  input  logic        [31:0] inv_width_i,
  output logic               ok_o,
  output logic        [53:0] sq_o
);

  localparam logic [47:0] P1_LIMIT = 48'h1000;
  localparam logic [63:0] P0_LIMIT = 64'h0000_1000_0000_0000;

  logic signed [48:0] pos2_d, pos2_q;
  logic signed [49:0] d2;
  logic        [47:0] ad_d, ad_q;
  logic        [47:0] p1_d, p1_q;
  logic        [63:0] p0_d, p0_q;
  logic        [44:0] prod;
  logic        [27:0] uq_r;
  logic               ok4_d, ok4_q, ok5_q;
  logic        [26:0] uq_d, uq_q;
  logic        [53:0] sq_d, sq_q;

  // Stage 1: twice the cell centre, (2i+1)*dx
  assign pos2_d = $signed({cell_i, 1'b1}) * $signed({1'b0, cell_size_i});

  // Stage 2: absolute doubled offset from the bump centre
  always_comb begin
    d2   = 50'(pos2_q) - $signed({{17{center_i[31]}}, center_i, 1'b0});
    ad_d = d2[49] ? 48'(-d2) : 48'(d2);
  end

  // Stage 3: scale by inverse width in two partial products
  assign p1_d = 48'(ad_q[47:32]) * 48'(inv_width_i);
  assign p0_d = 64'(ad_q[31:0]) * 64'(inv_width_i);

  // Stage 4: saturate at |u| >= 8, round to Q4.24; a value that rounds up
  // to exactly 8 lies outside the table as well, so it saturates too
  always_comb begin
    prod  = 45'({p1_q[11:0], 32'h0}) + 45'(p0_q[43:0]);
    uq_r  = 28'((prod + 45'h1_0000) >> 17);
    ok4_d = (p1_q < P1_LIMIT) && (p0_q < P0_LIMIT) && !prod[44] && !uq_r[27];
    uq_d  = uq_r[26:0];
  end

  // Stage 5: square
  assign sq_d = 54'(uq_q) * 54'(uq_q);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pos2_q <= pos2_d;
      ad_q   <= ad_d;
      p1_q   <= p1_d;
      p0_q   <= p0_d;
      ok4_q  <= ok4_d;
      uq_q   <= uq_d;
      ok5_q  <= ok4_q;
      sq_q   <= sq_d;
    end
  end

  assign ok_o = ok5_q;
  assign sq_o = sq_q;

endmodule

// ===== hw/rtl/gbf_exp.sv =====
// exp(-r2) by table lookup with linear interpolation, three register stages.
// Depends on gbf_pkg for the table and its widths.
module gbf_exp
  import gbf_pkg::*;
(
  input  logic        clk_i,
  input  logic        en_i,
  input  logic        ok_i,
  input  logic [53:0] sq_x_i,
  input  logic [53:0] sq_y_i,
  output logic [16:0] ev_o
);

  logic [54:0]          r2;
  logic [EXP_P_W-1:0]   p;
  logic                 hit_d, hit_q, hit7_q;
  logic [EXP_K_W-1:0]   k_q;
  logic [31:0]          f_q, f7_q;
  logic [16:0]          t0_d, t1_d, t0_q, diff_q;
  logic [48:0]          ip;
  logic [16:0]          ev_d, ev_q;

  // Stage 6: sum of squares, range check, table position
  always_comb begin
    r2    = 55'(sq_x_i) + 55'(sq_y_i);
    hit_d = ok_i && !r2[54];
    p     = EXP_P_W'(r2[53:22]) * EXP_P_W'(EXP_TABLE_ENTRIES);
  end

  // Stage 7: read neighboring table entries
  always_comb begin
    t0_d = EXP_TAB[EXP_IDX_W'(k_q)];
    t1_d = EXP_TAB[EXP_IDX_W'(k_q) + EXP_IDX_W'(1)];
  end

  // Stage 8: interpolate; zero outside the table
  always_comb begin
    ip   = 49'(diff_q) * 49'(f7_q);
    ev_d = hit7_q ? (t0_q - 17'(ip >> 32)) : 17'd0;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hit_q  <= hit_d;
      k_q    <= p[EXP_P_W-1:32];
      f_q    <= p[31:0];
      hit7_q <= hit_q;
      f7_q   <= f_q;
      t0_q   <= t0_d;
      diff_q <= t0_d - t1_d;
      ev_q   <= ev_d;
    end
  end

  assign ev_o = ev_q;

endmodule

// ===== hw/rtl/gbf_scale.sv =====
// Final scaling C0*(1 - a*E) with two roundings, two register stages.
// Depends on gbf_pkg.
module gbf_scale
  import gbf_pkg::*;
(
  input  logic               clk_i,
  input  logic               en_i,
  input  logic        [31:0] c0_i,
  input  logic signed [17:0] a_i,
  input  logic        [16:0] ev_i,
  output logic signed [35:0] coefficient_o
);

  logic signed [35:0] ae;
  logic signed [36:0] m;
  logic signed [36:0] m_r;
  logic signed [20:0] m16_q;
  logic signed [53:0] cm;
  logic signed [53:0] cm_r;
  logic signed [35:0] res_q;

  // Stage 9: m = 1 - a*E in Q.32, round to Q.16
  always_comb begin
    ae  = a_i * $signed({1'b0, ev_i});
    m   = 37'sh1_0000_0000 - 37'(ae);
    m_r = (m + 37'sh8000) >>> 16;
  end

  // Stage 10: multiply by C0, round to Q19.16
  always_comb begin
    cm   = $signed({1'b0, c0_i}) * m16_q;
    cm_r = cm + 54'sh8000;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m16_q <= m_r[20:0];
      res_q <= cm_r[51:16];
    end
  end

  assign coefficient_o = res_q;

endmodule

// ===== hw/rtl/gaussian_bump_field_eval.sv =====
// Gaussian bump field evaluator: one friction coefficient per grid cell.
// Channels: in_i takes a request of two signed cell indices, out_o returns
//   one signed Q19.16 coefficient per request, in request order.
// Configuration: cfg_we_i writes cfg_data_i into register cfg_idx_i (0..7);
//   other indices are ignored. Write only while no request is in flight.
// Pipeline: ten register stages, the first loaded at acceptance.
//   Throughput: one request per cycle unless a result is held at out_o;
//   a single pipe enable lets every stage advance together.
// Stall: while a result waits and out_o.ready is low, the whole pipe holds
//   and in_i.ready drops; nothing is lost or repeated. With out_o.ready high
//   in_i.ready is high.
// Reset: rst_ni low clears the valid bits and loads the register defaults
//   (C0 = 1.0, depth 0, centre 0, inverse widths 0, cell size 1.0).
// Exp table: fixed contents, built at elaboration, no clearing pass.
// Depends on gbf_pkg, gbf_in_if, gbf_out_if, gbf_axis, gbf_exp, gbf_scale.
module gaussian_bump_field_eval
  import gbf_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  gbf_in_if.sink                in_i,
  gbf_out_if.source             out_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int Stages = 10;

  logic        [31:0] base_coef_q;
  logic signed [17:0] bump_depth_q;
  logic signed [31:0] center_x_q, center_y_q;
  logic        [31:0] inv_w_x_q, inv_w_y_q;
  logic        [30:0] cell_x_q, cell_y_q;

  logic [Stages-1:0] valid_q;
  logic              en;
  logic              ok_x, ok_y;
  logic [53:0]       sq_x, sq_y;
  logic [16:0]       ev;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_coef_q  <= 32'h0001_0000;
      bump_depth_q <= '0;
      center_x_q   <= '0;
      center_y_q   <= '0;
      inv_w_x_q    <= '0;
      inv_w_y_q    <= '0;
      cell_x_q     <= 31'd256;
      cell_y_q     <= 31'd256;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_BASE_COEF:  base_coef_q  <= cfg_data_i;
        REG_BUMP_DEPTH: bump_depth_q <= cfg_data_i[17:0];
        REG_CENTER_X:   center_x_q   <= cfg_data_i;
        REG_CENTER_Y:   center_y_q   <= cfg_data_i;
        REG_INV_W_X:    inv_w_x_q    <= cfg_data_i;
        REG_INV_W_Y:    inv_w_y_q    <= cfg_data_i;
        REG_CELL_X:     cell_x_q     <= cfg_data_i[30:0];
        REG_CELL_Y:     cell_y_q     <= cfg_data_i[30:0];
        default: ;
      endcase
    end
  end

  // Advance the pipe unless a result is held at the output
  assign en         = !valid_q[Stages-1] || out_o.ready;
  assign in_i.ready = en;

  // Carry valid bits alongside the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en) begin
      valid_q <= {valid_q[Stages-2:0], in_i.valid};
    end
  end

  gbf_axis u_axis_x (
    .clk_i       (clk_i),
    .en_i        (en),
    .cell_i      (in_i.cell_i),
    .cell_size_i (cell_x_q),
    .center_i    (center_x_q),
    .inv_width_i (inv_w_x_q),
    .ok_o        (ok_x),
    .sq_o        (sq_x)
  );

  gbf_axis u_axis_y (
    .clk_i       (clk_i),
    .en_i        (en),
    .cell_i      (in_i.cell_j),
    .cell_size_i (cell_y_q),
    .center_i    (center_y_q),
    .inv_width_i (inv_w_y_q),
    .ok_o        (ok_y),
    .sq_o        (sq_y)
  );

  gbf_exp u_exp (
    .clk_i  (clk_i),
    .en_i   (en),
    .ok_i   (ok_x && ok_y),
    .sq_x_i (sq_x),
    .sq_y_i (sq_y),
    .ev_o   (ev)
  );

  gbf_scale u_scale (
    .clk_i         (clk_i),
    .en_i          (en),
    .c0_i          (base_coef_q),
    .a_i           (bump_depth_q),
    .ev_i          (ev),
    .coefficient_o (out_o.coefficient)
  );

  assign out_o.valid = valid_q[Stages-1];

endmodule

// ===== hw/rtl/gbf_checker.sv =====
// Port-level checks for gaussian_bump_field_eval, attached by bind.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module gbf_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input logic signed [35:0] coefficient_i
);

  // A stalled result stays offered
  `CHK_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i)

  // A stalled result keeps its value
  `CHK_NEXT(a_out_stable, clk_i, rst_ni, out_valid_i && !out_ready_i, $stable(coefficient_i))

  // A free sink never backpressures requests
  `CHK_IMPLY(a_no_bp, clk_i, rst_ni, out_ready_i, in_ready_i)

  // Nothing is offered right after reset
  `CHK_IMPLY(a_rst_empty, clk_i, rst_ni, $past(!rst_ni), !out_valid_i)

endmodule

bind gaussian_bump_field_eval gbf_checker u_gbf_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .coefficient_i (out_o.coefficient)
);

// ===== test/tb_top.sv =====
// Testbench for gaussian_bump_field_eval: directed table, then random cells near the bump.
// Checked against typed values or an in-bench bit-exact predictor with its own exp table.
// Depends on gbf_pkg, gbf_in_if, gbf_out_if and the block itself.
`timescale 1ns / 100ps

module tb_top;
  import gbf_pkg::*;

  localparam int N_TAB = EXP_TABLE_ENTRIES;
  localparam int RANDOM_PHASES = 8;
  localparam int ITEMS_PER_PHASE = 180;
  localparam int DRAIN_CYCLES = 14;
  localparam int LONG_HOLD_CYCLES = 80;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 4'd9;

  typedef struct {
    logic signed [15:0] ci;
    logic signed [15:0] cj;
    bit                 typed;
    logic signed [35:0] coef;
  } cell_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  gbf_in_if  in_ch ();
  gbf_out_if out_ch ();

  gaussian_bump_field_eval i_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_ch.sink),
    .out_o     (out_ch.source),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  // Shadow copy of the register file
  logic        [31:0] sh_c0 = 32'h0001_0000;
  logic signed [17:0] sh_depth = '0;
  logic signed [31:0] sh_cx = '0;
  logic signed [31:0] sh_cy = '0;
  logic        [31:0] sh_ivx = '0;
  logic        [31:0] sh_ivy = '0;
  logic        [30:0] sh_dx = 31'd256;
  logic        [30:0] sh_dy = 31'd256;

  logic [16:0] gauss_tab [0:N_TAB];

  logic signed [35:0] coef_queue[$];
  bit                 req_typed = 1'b0;
  logic signed [35:0] req_coef = '0;

  int errors = 0;
  int n_checked = 0;
  int n_settings = 0;
  int snd_idle = 0;
  int rcv_idle = 0;
  bit hold_tog = 1'b0;
  bit hold_seen = 1'b0;
  int hold_cnt = 0;
  int ccx = 0;
  int ccy = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Build exp(-64 k / N) in Q.16 with floor Q.62 products
  initial begin
    logic [127:0] acc;
    logic [63:0]  term;
    logic [63:0]  step;
    logic [63:0]  run;
    term = 64'd1 << 62;
    step = term;
    for (int k = 1; k < 64; k++) begin
      if (term != 0) begin
        term = term / (64'(k) * 64'(N_TAB));
        step = k[0] ? step - term : step + term;
      end
    end
    repeat (6) begin
      acc = 128'(step) * 128'(step);
      step = 64'(acc >> 62);
    end
    run = 64'd1 << 62;
    for (int k = 0; k <= N_TAB; k++) begin
      gauss_tab[k] = 17'((run + (64'd1 << 45)) >> 46);
      acc = 128'(run) * 128'(step);
      run = 64'(acc >> 62);
    end
  end

  // Scaled distance of one axis in Q4.24; returns 0 when it saturates
  function automatic bit axis_dist(input logic signed [15:0] idx, input logic [30:0] csize,
                                   input logic signed [31:0] ctr, input logic [31:0] inv,
                                   output logic [63:0] uq);
    longint      d2;
    logic [63:0] ad;
    logic [95:0] prod;
    d2 = (2 * longint'(idx) + 1) * longint'(csize) - 2 * longint'(ctr);
    ad = (d2 < 0) ? 64'(-d2) : 64'(d2);
    prod = 96'(ad) * 96'(inv);
    uq = 0;
    if (prod >= (96'd1 << 44)) return 1'b0;
    uq = 64'((prod + (96'd1 << 16)) >> 17);
    return 1'b1;
  endfunction

  function automatic logic signed [35:0] friction_at(input logic signed [15:0] ci,
                                                     input logic signed [15:0] cj);
    logic [63:0] ux;
    logic [63:0] uy;
    logic [63:0] r2;
    logic [63:0] p;
    logic [63:0] k;
    logic [63:0] f;
    logic [63:0] ev;
    logic [63:0] t0;
    logic [63:0] t1;
    bit          okx;
    bit          oky;
    longint      m;
    longint      m16;
    longint      res;
    ev = 0;
    okx = axis_dist(ci, sh_dx, sh_cx, sh_ivx, ux);
    oky = axis_dist(cj, sh_dy, sh_cy, sh_ivy, uy);
    if (okx && oky) begin
      r2 = ux * ux + uy * uy;
      if (r2 < (64'd1 << 54)) begin
        p = (r2 >> 22) * 64'(N_TAB);
        k = p >> 32;
        f = p & 64'hFFFF_FFFF;
        if (k >= N_TAB) k = N_TAB - 1;
        t0 = gauss_tab[k];
        t1 = gauss_tab[k + 1];
        ev = t0 - (((t0 - t1) * f) >> 32);
      end
    end
    m = (longint'(1) << 32) - longint'(sh_depth) * longint'(ev);
    m16 = (m + (longint'(1) << 15)) >>> 16;
    res = (longint'(sh_c0) * m16 + (longint'(1) << 15)) >>> 16;
    return 36'(res);
  endfunction

  task automatic report_mismatch(input string what, input logic signed [35:0] got,
                                 input logic signed [35:0] want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // Queue a typed or predicted value per accepted request, compare every accepted result
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_ch.valid && in_ch.ready)
        coef_queue.push_back(req_typed ? req_coef : friction_at(in_ch.cell_i, in_ch.cell_j));
      if (out_ch.valid && out_ch.ready) begin
        if (coef_queue.size() == 0) begin
          report_mismatch("unexpected result", out_ch.coefficient, '0);
        end else begin
          logic signed [35:0] want;
          want = coef_queue.pop_front();
          n_checked++;
          if (out_ch.coefficient !== want) report_mismatch("coefficient", out_ch.coefficient, want);
        end
      end
    end
  end

  // Result side: random stalls, plus a long hold-off on request
  always @(posedge clk_i) begin
    if (hold_cnt > 0) begin
      out_ch.ready <= 1'b0;
      hold_cnt <= hold_cnt - 1;
    end else if (hold_tog != hold_seen) begin
      hold_seen <= hold_tog;
      hold_cnt <= LONG_HOLD_CYCLES;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= rcv_idle);
    end
  end

  task automatic send_cell(input logic signed [15:0] ci, input logic signed [15:0] cj,
                           input bit typed, input logic signed [35:0] coef);
    if ($urandom_range(0, 99) < snd_idle) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.cell_i <= ci;
    in_ch.cell_j <= cj;
    req_typed <= typed;
    req_coef <= coef;
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  // Hold off requests until every expected result has come back, after first
  // letting the last accepted request reach the queue
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (coef_queue.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    case (idx)
      REG_BASE_COEF:  sh_c0 = val;
      REG_BUMP_DEPTH: sh_depth = val[17:0];
      REG_CENTER_X:   sh_cx = val;
      REG_CENTER_Y:   sh_cy = val;
      REG_INV_W_X:    sh_ivx = val;
      REG_INV_W_Y:    sh_ivy = val;
      REG_CELL_X:     sh_dx = val[30:0];
      REG_CELL_Y:     sh_dy = val[30:0];
      default: ;
    endcase
  endtask

  task automatic load_setting(input logic [31:0] c0, input logic [31:0] depth,
                              input logic [31:0] cx, input logic [31:0] cy,
                              input logic [31:0] ivx, input logic [31:0] ivy,
                              input logic [31:0] dx, input logic [31:0] dy);
    drain();
    write_reg(REG_BASE_COEF, c0);
    write_reg(REG_BUMP_DEPTH, depth);
    write_reg(REG_CENTER_X, cx);
    write_reg(REG_CENTER_Y, cy);
    write_reg(REG_INV_W_X, ivx);
    write_reg(REG_INV_W_Y, ivy);
    write_reg(REG_CELL_X, dx);
    write_reg(REG_CELL_Y, dy);
    write_reg(REG_UNUSED, $urandom);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    n_settings++;
  endtask

  // Inverse width so that a few dozen cells span the interesting exp range
  function automatic logic [31:0] pick_inv(input logic [30:0] csize);
    logic [63:0] span;
    if ($urandom_range(0, 9) == 0) return $urandom;
    span = (64'd1 << 44) / (64'd48 * 64'(csize == 0 ? 31'd1 : csize));
    if (span > 64'hFFFF_FFFF) span = 64'hFFFF_FFFF;
    return $urandom_range(0, 32'(span));
  endfunction

  task automatic random_setting();
    logic [30:0] dx;
    logic [30:0] dy;
    dx = ($urandom_range(0, 9) == 0) ? 31'($urandom) : 31'($urandom_range(1, 4096));
    dy = ($urandom_range(0, 9) == 0) ? 31'($urandom) : 31'($urandom_range(1, 4096));
    ccx = int'($urandom_range(0, 4000)) - 2000;
    ccy = int'($urandom_range(0, 4000)) - 2000;
    load_setting($urandom, $urandom,
                 32'(longint'(ccx) * longint'(dx) + $urandom_range(0, 255)),
                 32'(longint'(ccy) * longint'(dy) + $urandom_range(0, 255)),
                 pick_inv(dx), pick_inv(dy), 32'(dx), 32'(dy));
  endtask

  task automatic random_cell(output logic signed [15:0] ci, output logic signed [15:0] cj);
    if ($urandom_range(0, 99) < 15) begin
      ci = 16'($urandom);
      cj = 16'($urandom);
    end else begin
      ci = 16'(ccx + int'($urandom_range(0, 48)) - 24);
      cj = 16'(ccy + int'($urandom_range(0, 48)) - 24);
    end
  endtask

  initial begin
    cell_row_t rows[$];
    logic signed [15:0] ci;
    logic signed [15:0] cj;

    in_ch.valid = 1'b0;
    in_ch.cell_i = '0;
    in_ch.cell_j = '0;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset defaults: depth zero, so every cell gives C0 = 1.0
    rows = '{'{16'sd0, 16'sd0, 1, 36'sd65536},
             '{16'sd32767, 16'sd32767, 1, 36'sd65536},
             '{-16'sd32768, -16'sd32768, 1, 36'sd65536},
             '{16'sd32767, -16'sd32768, 1, 36'sd65536},
             '{-16'sd1, 16'sd0, 1, 36'sd65536}};
    foreach (rows[r]) send_cell(rows[r].ci, rows[r].cj, rows[r].typed, rows[r].coef);

    // Most negative depth with largest C0 gives the tallest peak;
    // far cells saturate back to C0
    load_setting(32'hFFFF_FFFF, 32'h0002_0000, '0, '0, 32'h8000_0000, 32'h8000_0000,
                 32'd256, 32'd256);
    rows = '{'{16'sd0, 16'sd0, 0, '0},
             '{-16'sd1, -16'sd1, 0, '0},
             '{16'sd0, -16'sd1, 0, '0},
             '{16'sd3, 16'sd2, 0, '0},
             '{16'sd100, 16'sd100, 1, 36'sd4294967295},
             '{16'sd32767, -16'sd32768, 1, 36'sd4294967295}};
    foreach (rows[r]) send_cell(rows[r].ci, rows[r].cj, rows[r].typed, rows[r].coef);

    // Zero cell size on x, zero inverse width on y: r2 is 0 everywhere
    load_setting(32'h0001_0000, 32'h0001_FFFF, '0, 32'h7FFF_FFFF, 32'h4000_0000, '0,
                 '0, 32'h7FFF_FFFF);
    rows = '{'{16'sd0, 16'sd0, 1, -36'sd65535},
             '{16'sd32767, -16'sd32768, 1, -36'sd65535},
             '{-16'sd32768, 16'sd32767, 1, -36'sd65535},
             '{16'sd1234, -16'sd77, 1, -36'sd65535}};
    foreach (rows[r]) send_cell(rows[r].ci, rows[r].cj, rows[r].typed, rows[r].coef);

    // Zero C0 with extreme centres
    load_setting('0, 32'h0001_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
                 32'hFFFF_FFFF, 32'd1, 32'd1);
    rows = '{'{16'sd0, 16'sd0, 1, 36'sd0},
             '{16'sd32767, -16'sd32768, 1, 36'sd0},
             '{-16'sd32768, 16'sd32767, 1, 36'sd0}};
    foreach (rows[r]) send_cell(rows[r].ci, rows[r].cj, rows[r].typed, rows[r].coef);

    // Random part: sender/receiver idle mix changes across phases
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      random_setting();
      if (ph < 3) begin
        snd_idle = 36;
        rcv_idle = 49;
      end else if (ph < 6) begin
        snd_idle = 49;
        rcv_idle = 36;
      end else begin
        snd_idle = 0;
        rcv_idle = 0;
      end
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (ph == 1 && n == 40) hold_tog <= ~hold_tog;
        if (ph == 6 && n == 20) hold_tog <= ~hold_tog;
        if (ph == 2 && n == 90) drain();
        random_cell(ci, cj);
        send_cell(ci, cj, 1'b0, '0);
      end
    end

    drain();
    $display("Checked %0d coefficients across %0d register settings,", n_checked, n_settings);
    $display("including saturation, zero widths, zero cell sizes and long output stalls.");
    if (errors == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #4_000_000;
    $display("Timeout with %0d results outstanding", coef_queue.size());
    $display("tb_top NOT OK");
    $finish;
  end

endmodule
